FILE: rtl/assert_macros.svh
// Assertion macros for the checker file.
// Depends on nothing; the including module provides clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is asserted
`define FCC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that also holds during reset
`define FCC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: rtl/fcc_pkg.sv
// Package for the frame CRC-16 check unit: constants, register codes, CRC helpers.
// No dependencies.
package fcc_pkg;

  localparam logic [15:0] CrcInit  = 16'hFFFF;
  localparam logic [15:0] CrcPoly  = 16'h1021;
  localparam logic [8:0]  PosLimit = 9'd511;

  localparam logic [7:0] RegionStartRst  = 8'd2;
  localparam logic [7:0] RegionLengthRst = 8'd33;

  // Configuration register indexes
  typedef enum logic [7:0] {
    CFG_REGION_START  = 8'd0,
    CFG_REGION_LENGTH = 8'd1
  } cfg_index_e;

  // One byte of CRC-16/CCITT-FALSE, MSB first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  // Check byte k of the split CRC: top 7 bits, middle 7 bits, low 2 bits
  function automatic logic [7:0] split_value(input logic [15:0] crc, input logic [1:0] k);
    logic [7:0] v;
    case (k)
      2'd0:    v = {1'b0, crc[15:9]};
      2'd1:    v = {1'b0, crc[8:2]};
      default: v = {6'd0, crc[1:0]};
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/frame_crc16_check_unit.sv
// A byte accepted from the input goes through the input register into the frame state, and
// a last byte's result goes on into the result register. Throughput: one byte per cycle;
// a last byte waits in the input register, stalling the input, while an earlier result is stalled.
// Reset (async, active low): CRC 0xFFFF, position 0, no mismatch, region
// registers back to start 2 and length 33, both pipeline stages empty.
// Depends on fcc_pkg.
module frame_crc16_check_unit
  import fcc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] computed_crc_o,
  output logic        crc_present_o,
  output logic        check_present_o,
  output logic        frame_valid_o,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  logic [7:0]  region_start_q, region_length_q;
  logic        s1_valid_q, s1_last_q;
  logic [7:0]  s1_data_q;
  logic [15:0] crc_q, crc_d;
  logic [8:0]  pos_q, pos_d;
  logic        mismatch_q, mismatch_d;
  logic        out_valid_q;
  logic [15:0] out_crc_q;
  logic        out_crc_ok_q, out_chk_ok_q, out_valid_frame_q;

  logic        in_take, s1_advance, out_free, out_load;
  logic [8:0]  region_end;
  logic [9:0]  check_end;
  logic        in_region, in_check, pos_full;
  logic [8:0]  check_off;
  logic        crc_ok, chk_ok;

  // Handshakes
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign s1_advance  = s1_valid_q && (!s1_last_q || out_free);
  assign out_load    = s1_advance && s1_last_q;
  assign in_stall_o  = s1_valid_q && !s1_advance;
  assign in_take     = in_valid_i && !in_stall_o;

  // Region bounds and where the registered byte falls
  assign region_end = {1'b0, region_start_q} + {1'b0, region_length_q};
  assign check_end  = {1'b0, region_end} + 10'd3;
  assign pos_full   = (pos_q == PosLimit);
  assign in_region  = (pos_q >= {1'b0, region_start_q}) && (pos_q < region_end);
  assign in_check   = (pos_q >= region_end) && ({1'b0, pos_q} < check_end);
  assign check_off  = pos_q - region_end;

  // Frame state update for the byte in stage 1
  always_comb begin
    crc_d      = crc_q;
    mismatch_d = mismatch_q;
    pos_d      = pos_q;
    if (!pos_full) begin
      if (in_region) begin
        crc_d = crc16_byte(crc_q, s1_data_q);
      end else if (in_check) begin
        if (s1_data_q != split_value(crc_q, check_off[1:0])) begin
          mismatch_d = 1'b1;
        end
      end
      pos_d = pos_q + 9'd1;
    end
  end

  assign crc_ok = (pos_d >= region_end);
  assign chk_ok = ({1'b0, pos_d} >= check_end);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_start_q  <= RegionStartRst;
      region_length_q <= RegionLengthRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_REGION_START:  region_start_q  <= cfg_data_i;
        CFG_REGION_LENGTH: region_length_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
    end else if (s1_advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_data_q <= data_byte_i;
      s1_last_q <= last_byte_i;
    end
  end

  // Running frame state, cleared after the last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q      <= CrcInit;
      pos_q      <= '0;
      mismatch_q <= 1'b0;
    end else if (s1_advance) begin
      if (s1_last_q) begin
        crc_q      <= CrcInit;
        pos_q      <= '0;
        mismatch_q <= 1'b0;
      end else begin
        crc_q      <= crc_d;
        pos_q      <= pos_d;
        mismatch_q <= mismatch_d;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_crc_q         <= crc_ok ? crc_d : 16'd0;
      out_crc_ok_q      <= crc_ok;
      out_chk_ok_q      <= chk_ok;
      out_valid_frame_q <= crc_ok && chk_ok && !mismatch_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign computed_crc_o  = out_crc_q;
  assign crc_present_o   = out_crc_ok_q;
  assign check_present_o = out_chk_ok_q;
  assign frame_valid_o   = out_valid_frame_q;

endmodule

FILE: rtl/fcc_checker.sv
// Port-level checks for the frame CRC-16 check unit, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module fcc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] computed_crc_o,
  input logic        crc_present_o,
  input logic        check_present_o,
  input logic        frame_valid_o
);

  // No result is shown while reset is held
  `FCC_ASSERT_ALWAYS(a_rst_no_out, !rst_ni |-> !out_valid_o, "result valid during reset")

  // A stalled result stays offered
  `FCC_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o, "stalled result dropped")

  // Check bytes follow the region, so they cannot be present without it
  `FCC_ASSERT(a_chk_needs_crc, out_valid_o && check_present_o |-> crc_present_o, "check without region")

  // A valid frame needs both the region and the check bytes
  `FCC_ASSERT(a_valid_needs_all, out_valid_o && frame_valid_o |-> crc_present_o && check_present_o, "frame valid without check bytes")

  // An incomplete region reports a zero CRC
  `FCC_ASSERT(a_crc_zero, out_valid_o && !crc_present_o |-> computed_crc_o == 16'd0, "nonzero CRC on short frame")

endmodule

bind frame_crc16_check_unit fcc_checker u_fcc_checker (.*);

FILE: tb/tb_top.sv
// Self-checking testbench for frame_crc16_check_unit: sends framed byte streams and
// predicts every end-of-frame report (CRC, region/check presence, frame validity).
// Depends on fcc_pkg and rtl/frame_crc16_check_unit.sv.

// Expected end-of-frame report
typedef struct {
  logic [15:0] crc;
  logic        crc_present;
  logic        check_present;
  logic        frame_valid;
} frame_report_t;

// Tracks the frame state byte by byte and holds the reports still owed by the block
class frame_report_tracker;
  int unsigned   region_start = fcc_pkg::RegionStartRst;
  int unsigned   region_len   = fcc_pkg::RegionLengthRst;
  logic [15:0]   crc_acc      = fcc_pkg::CrcInit;
  int unsigned   byte_count   = 0;
  bit            check_bad    = 1'b0;
  frame_report_t pending[$];
  int            errors       = 0;

  // CRC-16/CCITT-FALSE, one data bit at a time, MSB first
  static function logic [15:0] crc_update(logic [15:0] crc, logic [7:0] d);
    logic [15:0] r;
    logic        feedback;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      feedback = r[15] ^ d[i];
      r = {r[14:0], 1'b0};
      if (feedback) begin
        r = r ^ fcc_pkg::CrcPoly;
      end
    end
    return r;
  endfunction

  // Check byte n: CRC bits 15..9, 8..2, then 1..0
  static function logic [7:0] check_byte(logic [15:0] crc, int n);
    case (n)
      0:       return {1'b0, crc[15:9]};
      1:       return {1'b0, crc[8:2]};
      default: return {6'd0, crc[1:0]};
    endcase
  endfunction

  function void set_reg(logic [7:0] idx, logic [7:0] value);
    if (idx == fcc_pkg::CFG_REGION_START) begin
      region_start = value;
    end else if (idx == fcc_pkg::CFG_REGION_LENGTH) begin
      region_len = value;
    end
  endfunction

  function int pending_count();
    return pending.size();
  endfunction

  // One accepted input item; a last byte queues the report it causes
  function void note_byte(logic [7:0] d, logic last);
    int unsigned   span_end;
    frame_report_t rep;
    span_end = region_start + region_len;
    // position saturates at 511; a byte arriving there is dropped
    if (byte_count < 511) begin
      if (byte_count >= region_start && byte_count < span_end) begin
        crc_acc = crc_update(crc_acc, d);
      end else if (byte_count >= span_end && byte_count < span_end + 3) begin
        if (d != check_byte(crc_acc, byte_count - span_end)) begin
          check_bad = 1'b1;
        end
      end
      byte_count++;
    end
    if (last) begin
      rep.crc_present   = byte_count >= span_end;
      rep.check_present = byte_count >= span_end + 3;
      rep.crc           = rep.crc_present ? crc_acc : 16'h0000;
      rep.frame_valid   = rep.crc_present && rep.check_present && !check_bad;
      pending = {pending, rep};
      crc_acc    = fcc_pkg::CrcInit;
      byte_count = 0;
      check_bad  = 1'b0;
    end
  endfunction

  function void compare_field(string label, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, label, want, got);
    end
  endfunction

  // One accepted result item, checked against the oldest pending report
  function void check_report(logic [15:0] crc, logic crc_p, logic chk_p, logic valid);
    frame_report_t want;
    if (pending.size() == 0) begin
      errors++;
      $display("%0t: report with no frame pending, expected none, actual crc 0x%0h",
               $time, crc);
      return;
    end
    want = pending.pop_front();
    compare_field("computed_crc", want.crc, crc);
    compare_field("crc_present", want.crc_present, crc_p);
    compare_field("check_present", want.check_present, chk_p);
    compare_field("frame_valid", want.frame_valid, valid);
  endfunction
endclass

module tb_top;
  import fcc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ItemTarget  = 1600;
  localparam int FrameTarget = 20;
  localparam int QuietFrom   = 1300;
  localparam int DrainCycles = 4;

  typedef enum {
    FRAME_GOOD,
    FRAME_BAD_CHECK,
    FRAME_BAD_REGION,
    FRAME_SHORT,
    FRAME_NOISE,
    FRAME_LONG
  } frame_kind_e;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b1;
  logic        in_valid_i      = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i     = 8'h00;
  logic        last_byte_i     = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i     = 1'b0;
  logic [15:0] computed_crc_o;
  logic        crc_present_o;
  logic        check_present_o;
  logic        frame_valid_o;
  logic        cfg_valid_i     = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_index_i     = 8'h00;
  logic [7:0]  cfg_data_i      = 8'h00;

  frame_report_tracker tracker = new();

  int idle_pct    = 0;
  bit quiet_tail  = 1'b0;
  int bytes_sent  = 0;
  int frames_sent = 0;

  frame_crc16_check_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .data_byte_i     (data_byte_i),
    .last_byte_i     (last_byte_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .computed_crc_o  (computed_crc_o),
    .crc_present_o   (crc_present_o),
    .check_present_o (check_present_o),
    .frame_valid_o   (frame_valid_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // Report monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      tracker.check_report(computed_crc_o, crc_present_o, check_present_o, frame_valid_o);
    end
  end

  // Receiver stalls in random bursts
  always begin
    @(posedge clk_i);
    if (!quiet_tail && $urandom_range(1, 100) <= idle_pct) begin
      out_stall_i <= 1'b1;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
      out_stall_i <= 1'b0;
    end
  end

  // Run limit
  initial begin
    #4_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // One input item, with an optional idle burst ahead of it
  task automatic send_byte(logic [7:0] d, logic last);
    if (!quiet_tail && $urandom_range(1, 100) <= idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= d;
    last_byte_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    tracker.note_byte(d, last);
    bytes_sent++;
    if (bytes_sent >= QuietFrom) quiet_tail = 1'b1;
  endtask

  task automatic send_listed(logic [7:0] fb[$]);
    foreach (fb[k]) begin
      send_byte(fb[k], k == fb.size() - 1);
    end
    frames_sent++;
  endtask

  // Build a frame for the current region setting, then bend it as the kind asks
  task automatic send_frame(frame_kind_e kind);
    logic [7:0]  fb[$];
    logic [15:0] crc;
    int          span_start;
    int          span_end;
    int          flen;
    span_start = tracker.region_start;
    span_end   = span_start + tracker.region_len;
    crc        = CrcInit;
    for (int k = 0; k < span_end; k++) begin
      fb = {fb, 8'($urandom)};
      if (k >= span_start) begin
        crc = tracker.crc_update(crc, fb[k]);
      end
    end
    for (int k = 0; k < 3; k++) begin
      fb = {fb, tracker.check_byte(crc, k)};
    end
    flen = fb.size() + $urandom_range(0, 4);
    case (kind)
      FRAME_BAD_CHECK: begin
        fb[span_end + $urandom_range(0, 2)] ^= 8'(1 << $urandom_range(0, 7));
      end
      FRAME_BAD_REGION: begin
        if (span_end > span_start) begin
          fb[$urandom_range(span_start, span_end - 1)] ^= 8'(1 << $urandom_range(0, 7));
        end
      end
      FRAME_SHORT: begin
        flen = $urandom_range(1, span_end + 2);
      end
      FRAME_NOISE: begin
        flen = $urandom_range(1, 60);
        foreach (fb[k]) fb[k] = 8'($urandom);
      end
      FRAME_LONG: begin
        flen = $urandom_range(512, 530);
      end
      default: ;
    endcase
    while (fb.size() < flen) fb = {fb, 8'($urandom)};
    while (fb.size() > flen) void'(fb.pop_back());
    send_listed(fb);
  endtask

  // Hold input until every report is back, then let the pipeline settle
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (tracker.pending_count() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [7:0] idx, logic [7:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.set_reg(idx, value);
  endtask

  // Region setup between frames; sometimes also hits an unmapped index
  task automatic program_region(logic [7:0] start_v, logic [7:0] len_v);
    wait_drained();
    write_cfg(CFG_REGION_START, start_v);
    if ($urandom_range(0, 1) == 1) begin
      write_cfg(8'($urandom_range(2, 255)), 8'($urandom));
    end
    write_cfg(CFG_REGION_LENGTH, len_v);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    logic [7:0]  opening[$];
    int          phase;
    int          n_frames;
    int          pick;
    int          start_v;
    int          len_v;
    frame_kind_e kind;

    rst_ni <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset region with frames too short for it, then tiny and empty regions
    opening = {8'h00, 8'hFF, 8'h5A};
    send_listed(opening);
    opening = {8'hFF};
    send_listed(opening);
    program_region(8'd0, 8'd1);
    send_frame(FRAME_GOOD);
    send_frame(FRAME_BAD_CHECK);
    program_region(8'd2, 8'd0);
    send_frame(FRAME_GOOD);
    send_frame(FRAME_SHORT);

    // Random phases: the reset setting and extreme settings first, then mostly small regions
    phase = 0;
    while (bytes_sent < ItemTarget || frames_sent < FrameTarget) begin
      case (phase)
        0: begin
          start_v = RegionStartRst;
          len_v   = RegionLengthRst;
        end
        1: begin
          start_v = 0;
          len_v   = 0;
        end
        2: begin
          start_v = 200;
          len_v   = 200;
        end
        3: begin
          start_v = 255;
          len_v   = 255;
        end
        default: begin
          if ($urandom_range(0, 9) == 0) begin
            start_v = $urandom_range(0, 255);
            len_v   = $urandom_range(0, 255);
          end else begin
            start_v = $urandom_range(0, 6);
            len_v   = $urandom_range(0, 40);
          end
        end
      endcase
      program_region(8'(start_v), 8'(len_v));
      case ($urandom_range(0, 2))
        0:       idle_pct = 0;
        1:       idle_pct = 15;
        default: idle_pct = 40;
      endcase
      n_frames = (start_v + len_v > 100) ? 1 : $urandom_range(3, 8);
      repeat (n_frames) begin
        pick = $urandom_range(0, 99);
        if (pick < 65) kind = FRAME_GOOD;
        else if (pick < 75) kind = FRAME_BAD_CHECK;
        else if (pick < 80) kind = FRAME_BAD_REGION;
        else if (pick < 92) kind = FRAME_SHORT;
        else if (pick < 98) kind = FRAME_NOISE;
        else kind = FRAME_LONG;
        send_frame(kind);
      end
      phase++;
    end

    wait_drained();
    if (tracker.errors == 0 && tracker.pending_count() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
